// ===== rtl/lpg_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lpg_pkg
// Shared constants, codes and helper functions of the line pixel generator.
// ============================================================================
package lpg_pkg;

    // Frame dimension registers.
    localparam int DIM_BITS       = 13;
    localparam int MAX_DIM        = 4096;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

    // Result fields with fixed widths.
    localparam int INDEX_BITS = 24;
    localparam int COLOR_BITS = 24;
    localparam int WORD_BITS  = 32;
    localparam logic [7:0] ALPHA_BYTE = 8'hFF;

    // Defaults of the top level parameters.
    localparam int COORD_BITS_DEFAULT  = 14;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        FUNC_START   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        OCT_X_RISE = 2'd0,
        OCT_Y_RISE = 2'd1,
        OCT_X_FALL = 2'd2,
        OCT_Y_FALL = 2'd3
    } t_octant;

    // Width of the signed error term and its increments.
    function automatic int err_bits(input int cb);
        return cb + 4;
    endfunction

    // Width of one command word between the front end and the stepper:
    // start flag, octant, start point, error, step count, two increments, color.
    function automatic int cmd_bits(input int cb);
        return 1 + 2 + 2 * cb + 3 * err_bits(cb) + (cb + 1) + COLOR_BITS;
    endfunction

endpackage

// ===== rtl/lpg_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lpg_queue
// Small register FIFO that decouples the front end from the stepper.
// ============================================================================
module lpg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/lpg_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lpg_front
// Accepts requests and prepares start commands: orders the endpoints,
// picks the octant case and the error increments of the line.
// ============================================================================
module lpg_front #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic                                          i_func,
    input  logic signed [COORD_BITS-1:0]                  i_x_start,
    input  logic signed [COORD_BITS-1:0]                  i_y_start,
    input  logic signed [COORD_BITS-1:0]                  i_x_end,
    input  logic signed [COORD_BITS-1:0]                  i_y_end,
    input  logic [lpg_pkg::COLOR_BITS-1:0]                i_color,
    output logic                                          o_cmd_valid,
    input  logic                                          i_cmd_ready,
    output logic [lpg_pkg::cmd_bits(COORD_BITS)-1:0]      o_cmd
);
    import lpg_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EW = err_bits(COORD_BITS);

    logic                   r_valid;
    t_func                  r_func;
    logic signed [CB-1:0]   r_xs;
    logic signed [CB-1:0]   r_ys;
    logic signed [CB-1:0]   r_xe;
    logic signed [CB-1:0]   r_ye;
    logic [COLOR_BITS-1:0]  r_color;

    logic signed [EW-1:0]   w_sx, w_sy, w_ex, w_ey;
    logic signed [EW-1:0]   w_dx, w_dy;
    logic                   w_dx_neg, w_dy_neg, w_dx_zero, w_dy_zero, w_same;
    logic signed [EW-1:0]   w_adx, w_ody, w_tdx, w_tdy;
    logic signed [EW-1:0]   w_ox, w_oy;
    logic signed [EW-1:0]   w_err, w_steps, w_inc_a, w_inc_b;
    t_octant                w_oct;
    logic                   w_is_start;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_func  <= t_func'(i_func);
            r_xs    <= i_x_start;
            r_ys    <= i_y_start;
            r_xe    <= i_x_end;
            r_ye    <= i_y_end;
            r_color <= i_color;
        end
    end

    assign w_sx = EW'(r_xs);
    assign w_sy = EW'(r_ys);
    assign w_ex = EW'(r_xe);
    assign w_ey = EW'(r_ye);
    assign w_dx = w_ex - w_sx;
    assign w_dy = w_ey - w_sy;

    assign w_dx_neg  = w_dx[EW-1];
    assign w_dy_neg  = w_dy[EW-1];
    assign w_dx_zero = (w_dx == '0);
    assign w_dy_zero = (w_dy == '0);
    // Both deltas share a sign (zero counts as either): rising cases.
    assign w_same = (!w_dx_neg && !w_dy_neg) ||
                    ((w_dx_neg || w_dx_zero) && (w_dy_neg || w_dy_zero));

    // Ordering: x always runs upward; in the rising cases y is flipped on its
    // own, in the falling cases the endpoints swap as a pair.
    assign w_adx = w_dx_neg ? -w_dx : w_dx;
    assign w_ody = (w_same ? w_dy_neg : w_dx_neg) ? -w_dy : w_dy;
    assign w_ox  = w_dx_neg ? w_ex : w_sx;
    assign w_oy  = (w_same ? w_dy_neg : w_dx_neg) ? w_ey : w_sy;
    assign w_tdx = w_adx <<< 1;
    assign w_tdy = w_ody <<< 1;

    always_comb begin
        if (w_same) begin
            if (w_adx >= w_ody) begin
                w_oct   = OCT_X_RISE;
                w_err   = w_tdy - w_adx;
                w_steps = w_adx;
                w_inc_a = w_tdy;
            end else begin
                w_oct   = OCT_Y_RISE;
                w_err   = w_ody - w_tdx;
                w_steps = w_ody;
                w_inc_a = -w_tdx;
            end
            w_inc_b = w_tdy - w_tdx;
        end else begin
            if (w_adx >= -w_ody) begin
                w_oct   = OCT_X_FALL;
                w_err   = w_tdy + w_adx;
                w_steps = w_adx;
                w_inc_a = w_tdy;
            end else begin
                w_oct   = OCT_Y_FALL;
                w_err   = w_tdx + w_ody;
                w_steps = -w_ody;
                w_inc_a = w_tdx;
            end
            w_inc_b = w_tdy + w_tdx;
        end
    end

    assign w_is_start = (r_func == FUNC_START);

    assign o_cmd = {w_is_start, w_oct, w_ox[CB-1:0], w_oy[CB-1:0], w_err,
                    w_steps[CB:0], w_inc_a, w_inc_b, r_color};

endmodule

// ===== rtl/lpg_step.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lpg_step
// Bresenham stepper: loads start commands, emits a pixel per advance if busy.
// ============================================================================
module lpg_step #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cmd_valid,
    output logic                                          o_cmd_ready,
    input  logic [lpg_pkg::cmd_bits(COORD_BITS)-1:0]      i_cmd,
    output logic                                          o_pix_valid,
    input  logic                                          i_pix_ready,
    output logic signed [COORD_BITS-1:0]                  o_pix_x,
    output logic signed [COORD_BITS-1:0]                  o_pix_y,
    output logic                                          o_pix_last,
    output logic [lpg_pkg::COLOR_BITS-1:0]                o_pix_color
);
    import lpg_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EW = err_bits(COORD_BITS);

    logic                   c_is_start;
    logic [1:0]             c_oct;
    logic signed [CB-1:0]   c_x, c_y;
    logic signed [EW-1:0]   c_err, c_inc_a, c_inc_b;
    logic [CB:0]            c_steps;
    logic [COLOR_BITS-1:0]  c_color;

    logic                   r_busy;
    t_octant                r_oct;
    logic signed [CB-1:0]   r_x, r_y;
    logic signed [EW-1:0]   r_err, r_inc_a, r_inc_b;
    logic [CB:0]            r_steps;
    logic [COLOR_BITS-1:0]  r_color;

    logic                   r_pv;
    logic signed [CB-1:0]   r_px, r_py;
    logic                   r_plast;
    logic [COLOR_BITS-1:0]  r_pcolor;

    logic                   w_pix_free, w_pop, w_load, w_emit, w_last, w_take_b;
    logic signed [CB-1:0]   n_x, n_y;
    logic signed [EW-1:0]   n_err;

    assign {c_is_start, c_oct, c_x, c_y, c_err, c_steps, c_inc_a, c_inc_b, c_color} = i_cmd;

    // An advance needs room in the pixel register only while a line runs.
    assign w_pix_free  = !r_pv || i_pix_ready;
    assign o_cmd_ready = c_is_start || !r_busy || w_pix_free;
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_load      = w_pop && c_is_start;
    assign w_emit      = w_pop && !c_is_start && r_busy;
    assign w_last      = (r_steps == '0);

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        case (r_oct)
            OCT_X_RISE: begin
                w_take_b = !r_err[EW-1];
                n_x      = r_x + 1'b1;
                n_y      = r_y + CB'(w_take_b);
            end
            OCT_Y_RISE: begin
                w_take_b = r_err[EW-1] || (r_err == '0);
                n_x      = r_x + CB'(w_take_b);
                n_y      = r_y + 1'b1;
            end
            OCT_X_FALL: begin
                // A tie keeps y in this case.
                w_take_b = r_err[EW-1];
                n_x      = r_x + 1'b1;
                n_y      = r_y - CB'(w_take_b);
            end
            OCT_Y_FALL: begin
                w_take_b = !r_err[EW-1];
                n_x      = r_x + CB'(w_take_b);
                n_y      = r_y - 1'b1;
            end
            default: begin
                w_take_b = 1'b0;
            end
        endcase
        n_err = r_err + (w_take_b ? r_inc_b : r_inc_a);
    end

    assign o_pix_valid = r_pv;
    assign o_pix_x     = r_px;
    assign o_pix_y     = r_py;
    assign o_pix_last  = r_plast;
    assign o_pix_color = r_pcolor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_emit && w_last) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_pv <= 1'b1;
            end else if (i_pix_ready) begin
                r_pv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oct   <= t_octant'(c_oct);
            r_x     <= c_x;
            r_y     <= c_y;
            r_err   <= c_err;
            r_steps <= c_steps;
            r_inc_a <= c_inc_a;
            r_inc_b <= c_inc_b;
            r_color <= c_color;
        end else if (w_emit && !w_last) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_err   <= n_err;
            r_steps <= r_steps - 1'b1;
        end
        if (w_emit) begin
            r_px     <= r_x;
            r_py     <= r_y;
            r_plast  <= w_last;
            r_pcolor <= r_color;
        end
    end

endmodule

// ===== rtl/lpg_pixel.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lpg_pixel
// Clips each pixel to the frame, forms its flipped frame index and holds
// the finished result in the output register.
// ============================================================================
module lpg_pixel #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [lpg_pkg::DIM_BITS-1:0]           i_frame_width,
    input  logic [lpg_pkg::DIM_BITS-1:0]           i_frame_height,
    input  logic                                   i_pix_valid,
    output logic                                   o_pix_ready,
    input  logic signed [COORD_BITS-1:0]           i_pix_x,
    input  logic signed [COORD_BITS-1:0]           i_pix_y,
    input  logic                                   i_pix_last,
    input  logic [lpg_pkg::COLOR_BITS-1:0]         i_pix_color,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [COORD_BITS-1:0]           o_pixel_x,
    output logic signed [COORD_BITS-1:0]           o_pixel_y,
    output logic                                   o_visible,
    output logic [lpg_pkg::INDEX_BITS-1:0]         o_pixel_index,
    output logic [lpg_pkg::WORD_BITS-1:0]          o_pixel_word,
    output logic                                   o_last
);
    import lpg_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int VW = ((CB > DIM_BITS) ? CB : DIM_BITS) + 2;
    localparam int PW = 2 * DIM_BITS;

    logic signed [VW-1:0]   w_xe, w_ye, w_we, w_he, w_row;
    logic                   w_vis, w_en_out, w_en_s1;
    logic [PW-1:0]          w_prod, w_sum;

    logic                   r_s1_valid;
    logic                   r_s1_vis;
    logic [DIM_BITS-1:0]    r_s1_row, r_s1_col;
    logic signed [CB-1:0]   r_s1_x, r_s1_y;
    logic                   r_s1_last;
    logic [COLOR_BITS-1:0]  r_s1_color;

    logic                   r_o_valid;
    logic signed [CB-1:0]   r_o_x, r_o_y;
    logic                   r_o_vis;
    logic [INDEX_BITS-1:0]  r_o_index;
    logic [COLOR_BITS-1:0]  r_o_color;
    logic                   r_o_last;

    assign w_en_out    = !r_o_valid || i_ready;
    assign w_en_s1     = !r_s1_valid || w_en_out;
    assign o_pix_ready = w_en_s1;

    assign w_xe  = VW'(i_pix_x);
    assign w_ye  = VW'(i_pix_y);
    assign w_we  = $signed({{(VW - DIM_BITS){1'b0}}, i_frame_width});
    assign w_he  = $signed({{(VW - DIM_BITS){1'b0}}, i_frame_height});
    assign w_vis = !w_xe[VW-1] && !w_ye[VW-1] && (w_xe < w_we) && (w_ye < w_he);
    assign w_row = w_he - VW'(1) - w_ye;

    assign w_prod = PW'(r_s1_row) * PW'(i_frame_width);
    assign w_sum  = w_prod + PW'(r_s1_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_en_s1) begin
                r_s1_valid <= i_pix_valid;
            end
            if (w_en_out) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_s1 && i_pix_valid) begin
            r_s1_vis   <= w_vis;
            r_s1_row   <= w_row[DIM_BITS-1:0];
            r_s1_col   <= w_xe[DIM_BITS-1:0];
            r_s1_x     <= i_pix_x;
            r_s1_y     <= i_pix_y;
            r_s1_last  <= i_pix_last;
            r_s1_color <= i_pix_color;
        end
        if (w_en_out && r_s1_valid) begin
            r_o_x     <= r_s1_x;
            r_o_y     <= r_s1_y;
            r_o_vis   <= r_s1_vis;
            r_o_index <= r_s1_vis ? w_sum[INDEX_BITS-1:0] : '0;
            r_o_color <= r_s1_color;
            r_o_last  <= r_s1_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_pixel_x     = r_o_x;
    assign o_pixel_y     = r_o_y;
    assign o_visible     = r_o_vis;
    assign o_pixel_index = r_o_index;
    assign o_pixel_word  = {ALPHA_BYTE, r_o_color};
    assign o_last        = r_o_last;

endmodule

// ===== rtl/line_pixel_generator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// line_pixel_generator
// Bresenham line generator with frame clipping and flipped frame indexing.
// ============================================================================
// Usage:
// Requests enter on the i_valid / o_ready channel. A start request
// (i_func = 0) carries both endpoints and the line color and yields no
// result; it replaces any line that is still running. Each advance request
// (i_func = 1) yields exactly one pixel while a line is running and nothing
// otherwise. A line gives max(|dx|,|dy|)+1 pixels, the final one with
// o_last set. Pixels outside the frame still come out, with o_visible low
// and a zero index.
// Results leave on the o_valid / i_ready channel through the front register,
// command queue, stepper pixel register, clip stage and output register. The
// block takes one request per cycle while nothing stalls; the rate is set by
// the stepper, which does one error add and one coordinate step per cycle.
// When the receiver stalls, the output register, clip stage, stepper, command
// queue and front register fill in turn before o_ready drops. Reset empties
// every stage and the queue, ends any running line and sets the frame to 640
// by 480. Frame registers are written over i_cfg_we; the user must write them
// only while the block is idle, which the block does not enforce. A zero is
// taken as one and values above the maximum dimension are clamped.
// ============================================================================
module line_pixel_generator #(
    parameter int COORD_BITS  = lpg_pkg::COORD_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = lpg_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port.
    input  logic                                   i_cfg_we,
    input  logic [lpg_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [lpg_pkg::DIM_BITS-1:0]           i_cfg_data,
    // Request channel.
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_func,
    input  logic signed [COORD_BITS-1:0]           i_x_start,
    input  logic signed [COORD_BITS-1:0]           i_y_start,
    input  logic signed [COORD_BITS-1:0]           i_x_end,
    input  logic signed [COORD_BITS-1:0]           i_y_end,
    input  logic [7:0]                             i_red,
    input  logic [7:0]                             i_green,
    input  logic [7:0]                             i_blue,
    // Result channel.
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [COORD_BITS-1:0]           o_pixel_x,
    output logic signed [COORD_BITS-1:0]           o_pixel_y,
    output logic                                   o_visible,
    output logic [lpg_pkg::INDEX_BITS-1:0]         o_pixel_index,
    output logic [lpg_pkg::WORD_BITS-1:0]          o_pixel_word,
    output logic                                   o_last
);
    import lpg_pkg::*;

    localparam int CMD_W = cmd_bits(COORD_BITS);

    // Frame size registers.
    logic [DIM_BITS-1:0]    r_frame_width;
    logic [DIM_BITS-1:0]    r_frame_height;
    logic [DIM_BITS-1:0]    w_cfg_clamped;

    // Front end to queue.
    logic                   w_f_valid, w_f_ready;
    logic [CMD_W-1:0]       w_f_cmd;
    // Queue to stepper.
    logic                   w_q_valid, w_q_ready;
    logic [CMD_W-1:0]       w_q_cmd;
    // Stepper to clip and index stage.
    logic                        w_p_valid, w_p_ready;
    logic signed [COORD_BITS-1:0] w_p_x, w_p_y;
    logic                        w_p_last;
    logic [COLOR_BITS-1:0]       w_p_color;

    // A zero dimension is taken as one, anything over the limit as the limit.
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_clamped = DIM_BITS'(1);
        end else if (int'(i_cfg_data) > MAX_DIM) begin
            w_cfg_clamped = DIM_BITS'(MAX_DIM);
        end else begin
            w_cfg_clamped = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_WIDTH:  r_frame_width  <= w_cfg_clamped;
                REG_FRAME_HEIGHT: r_frame_height <= w_cfg_clamped;
                default: begin
                end
            endcase
        end
    end

    // Front end: takes requests and prepares start commands.
    lpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .i_color     ({i_red, i_green, i_blue}),
        .o_cmd_valid (w_f_valid),
        .i_cmd_ready (w_f_ready),
        .o_cmd       (w_f_cmd)
    );

    // Command queue between the front end and the stepper.
    lpg_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_cmd),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_cmd)
    );

    // Stepper: holds the line state and walks it one pixel per advance.
    lpg_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_pix_valid (w_p_valid),
        .i_pix_ready (w_p_ready),
        .o_pix_x     (w_p_x),
        .o_pix_y     (w_p_y),
        .o_pix_last  (w_p_last),
        .o_pix_color (w_p_color)
    );

    // Clipping, frame index and output register.
    lpg_pixel #(
        .COORD_BITS (COORD_BITS)
    ) u_pixel (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_pix_valid    (w_p_valid),
        .o_pix_ready    (w_p_ready),
        .i_pix_x        (w_p_x),
        .i_pix_y        (w_p_y),
        .i_pix_last     (w_p_last),
        .i_pix_color    (w_p_color),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_visible      (o_visible),
        .o_pixel_index  (o_pixel_index),
        .o_pixel_word   (o_pixel_word),
        .o_last         (o_last)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking testbench of the line pixel generator. A queue of line
// requests is filled by the stimulus process and fed to the block by a
// clocked driver. A cycle-free line tracer predicts every pixel when its
// request is accepted. A clocked monitor compares each pixel, field by
// field, with the oldest predicted one. The run steps through several frame
// sizes and several sender and receiver pacing modes.
// ============================================================================
module tb_top;

    import lpg_pkg::*;

    localparam int CB = COORD_BITS_DEFAULT;

    // One request as it goes into the block. Coordinates are kept as raw
    // bit vectors and read back with $signed where arithmetic needs them.
    typedef struct packed {
        t_func         func;
        logic [CB-1:0] xs;
        logic [CB-1:0] ys;
        logic [CB-1:0] xe;
        logic [CB-1:0] ye;
        logic [7:0]    red;
        logic [7:0]    green;
        logic [7:0]    blue;
    } t_line_req;

    // One pixel as it leaves the block.
    typedef struct packed {
        logic [CB-1:0]         px;
        logic [CB-1:0]         py;
        logic                  vis;
        logic [INDEX_BITS-1:0] idx;
        logic [WORD_BITS-1:0]  word;
        logic                  is_last;
    } t_pixel;

    // Every input of the block has a known value from time zero.
    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [DIM_BITS-1:0]       i_cfg_data  = '0;
    logic                      i_valid     = 1'b0;
    logic                      i_func      = 1'b0;
    logic signed [CB-1:0]      i_x_start   = '0;
    logic signed [CB-1:0]      i_y_start   = '0;
    logic signed [CB-1:0]      i_x_end     = '0;
    logic signed [CB-1:0]      i_y_end     = '0;
    logic [7:0]                i_red       = '0;
    logic [7:0]                i_green     = '0;
    logic [7:0]                i_blue      = '0;
    logic                      i_ready     = 1'b0;

    logic                      o_ready;
    logic                      o_valid;
    logic signed [CB-1:0]      o_pixel_x;
    logic signed [CB-1:0]      o_pixel_y;
    logic                      o_visible;
    logic [INDEX_BITS-1:0]     o_pixel_index;
    logic [WORD_BITS-1:0]      o_pixel_word;
    logic                      o_last;

    line_pixel_generator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_visible     (o_visible),
        .o_pixel_index (o_pixel_index),
        .o_pixel_word  (o_pixel_word),
        .o_last        (o_last)
    );

    // 8 ns clock period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Requests waiting for the driver, and pixels waiting for the monitor.
    t_line_req line_reqs[$];
    t_pixel    pixel_expect[$];

    // Pacing knobs, in percent of cycles.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int err_count = 0;

    // Tracer copy of the frame registers and of the line in progress.
    int          frame_w    = 640;
    int          frame_h    = 480;
    int          cur_x      = 0;
    int          cur_y      = 0;
    int          steps_left = 0;
    int          err_term   = 0;
    int          twice_dx   = 0;
    int          twice_dy   = 0;
    t_octant     line_oct   = OCT_X_RISE;
    bit          line_busy  = 1'b0;
    logic [23:0] line_color = '0;

    // ------------------------------------------------------------------------
    // Line tracer
    // ------------------------------------------------------------------------

    // A frame register never holds zero and never exceeds the largest frame.
    function automatic int clamp_dim(input logic [DIM_BITS-1:0] v);
        if (v < 1) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // A start request orders the endpoints so that the stepper always walks
    // with rising x, or with rising y for steep rising lines, and picks the
    // octant case that tells which axis is the major one.
    function automatic void load_line(input t_line_req rq);
        int sx, sy, ex, ey, dx, dy, t;
        sx = $signed(rq.xs);
        sy = $signed(rq.ys);
        ex = $signed(rq.xe);
        ey = $signed(rq.ye);
        dx = ex - sx;
        dy = ey - sy;
        if ((dx >= 0 && dy >= 0) || (dx <= 0 && dy <= 0)) begin
            // Both deltas share a sign, so each axis is flipped on its own.
            if (dx < 0) begin
                t = sx; sx = ex; ex = t; dx = -dx;
            end
            if (dy < 0) begin
                t = sy; sy = ey; ey = t; dy = -dy;
            end
            if (dx >= dy) begin
                line_oct = OCT_X_RISE; err_term = 2 * dy - dx; steps_left = dx;
            end else begin
                line_oct = OCT_Y_RISE; err_term = dy - 2 * dx; steps_left = dy;
            end
        end else begin
            // Opposite signs: swap whole endpoints so that x rises.
            if (dx < 0) begin
                t = sx; sx = ex; ex = t;
                t = sy; sy = ey; ey = t;
                dx = -dx; dy = -dy;
            end
            if (dx >= -dy) begin
                line_oct = OCT_X_FALL; err_term = 2 * dy + dx; steps_left = dx;
            end else begin
                line_oct = OCT_Y_FALL; err_term = 2 * dx + dy; steps_left = -dy;
            end
        end
        cur_x      = sx;
        cur_y      = sy;
        twice_dx   = 2 * dx;
        twice_dy   = 2 * dy;
        line_color = {rq.red, rq.green, rq.blue};
        line_busy  = 1'b1;
    endfunction

    // An advance request emits the current pixel and then steps. When no
    // line is running it emits nothing and leaves the state alone.
    function automatic void advance_line();
        t_pixel px;
        bit     vis;
        int     idx;
        if (!line_busy) return;
        vis = cur_x >= 0 && cur_x < frame_w && cur_y >= 0 && cur_y < frame_h;
        idx = vis ? (frame_h - 1 - cur_y) * frame_w + cur_x : 0;
        px.px   = cur_x[CB-1:0];
        px.py   = cur_y[CB-1:0];
        px.vis  = vis;
        px.idx  = idx[INDEX_BITS-1:0];
        px.word = {ALPHA_BYTE, line_color};
        if (steps_left <= 0) begin
            px.is_last = 1'b1;
            line_busy  = 1'b0;
        end else begin
            px.is_last = 1'b0;
            // Only the falling x-major case leaves the minor axis alone on
            // an exact halfway tie.
            case (line_oct)
                OCT_X_RISE: begin
                    if (err_term < 0) begin
                        err_term += twice_dy;
                    end else begin
                        err_term += twice_dy - twice_dx;
                        cur_y++;
                    end
                    cur_x++;
                end
                OCT_Y_RISE: begin
                    if (err_term > 0) begin
                        err_term -= twice_dx;
                    end else begin
                        err_term += twice_dy - twice_dx;
                        cur_x++;
                    end
                    cur_y++;
                end
                OCT_X_FALL: begin
                    if (err_term >= 0) begin
                        err_term += twice_dy;
                    end else begin
                        err_term += twice_dy + twice_dx;
                        cur_y--;
                    end
                    cur_x++;
                end
                default: begin
                    if (err_term < 0) begin
                        err_term += twice_dx;
                    end else begin
                        err_term += twice_dy + twice_dx;
                        cur_x++;
                    end
                    cur_y--;
                end
            endcase
            steps_left--;
        end
        pixel_expect.push_back(px);
    endfunction

    // ------------------------------------------------------------------------
    // Driver and receiver
    // ------------------------------------------------------------------------

    t_line_req drv_req;
    bit        req_taken = 1'b0;

    // Acceptance is seen at the rising edge, where the tracer is advanced
    // with the request that was on the bus.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            req_taken = 1'b1;
            if (drv_req.func == FUNC_START) begin
                load_line(drv_req);
            end else begin
                advance_line();
            end
        end
    end

    // The bus is changed only at the falling edge, and only when it is empty
    // or its request has just been taken, so valid and payload hold steady
    // while the block is not ready.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || req_taken)) begin
            req_taken = 1'b0;
            if (line_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_req   = line_reqs.pop_front();
                i_valid   <= 1'b1;
                i_func    <= drv_req.func;
                i_x_start <= drv_req.xs;
                i_y_start <= drv_req.ys;
                i_x_end   <= drv_req.xe;
                i_y_end   <= drv_req.ye;
                i_red     <= drv_req.red;
                i_green   <= drv_req.green;
                i_blue    <= drv_req.blue;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // The receiver decides anew each cycle, at random, whether to stall.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------

    task automatic log_error(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            log_error($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : pixel_monitor
        t_pixel got;
        t_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            got.px      = o_pixel_x;
            got.py      = o_pixel_y;
            got.vis     = o_visible;
            got.idx     = o_pixel_index;
            got.word    = o_pixel_word;
            got.is_last = o_last;
            if (pixel_expect.size() == 0) begin
                log_error($sformatf("pixel (%0d,%0d) with none outstanding",
                                    o_pixel_x, o_pixel_y));
            end else begin
                want = pixel_expect.pop_front();
                compare_field("pixel_x", 32'(got.px), 32'(want.px));
                compare_field("pixel_y", 32'(got.py), 32'(want.py));
                compare_field("visible", 32'(got.vis), 32'(want.vis));
                compare_field("pixel_index", 32'(got.idx), 32'(want.idx));
                compare_field("pixel_word", got.word, want.word);
                compare_field("last", 32'(got.is_last), 32'(want.is_last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Queues a start request and returns the number of pixels of its line.
    function automatic int add_start(input int xs, ys, xe, ye, input int r, g, b);
        t_line_req rq;
        int        adx, ady;
        rq.func  = FUNC_START;
        rq.xs    = xs[CB-1:0];
        rq.ys    = ys[CB-1:0];
        rq.xe    = xe[CB-1:0];
        rq.ye    = ye[CB-1:0];
        rq.red   = r[7:0];
        rq.green = g[7:0];
        rq.blue  = b[7:0];
        line_reqs.push_back(rq);
        adx = (xe > xs) ? xe - xs : xs - xe;
        ady = (ye > ys) ? ye - ys : ys - ye;
        return ((adx > ady) ? adx : ady) + 1;
    endfunction

    // Advance requests carry random junk in the fields they do not use.
    task automatic add_advances(input int n);
        t_line_req rq;
        for (int k = 0; k < n; k++) begin
            rq.func  = FUNC_ADVANCE;
            rq.xs    = CB'($urandom_range(16383));
            rq.ys    = CB'($urandom_range(16383));
            rq.xe    = CB'($urandom_range(16383));
            rq.ye    = CB'($urandom_range(16383));
            rq.red   = 8'($urandom_range(255));
            rq.green = 8'($urandom_range(255));
            rq.blue  = 8'($urandom_range(255));
            line_reqs.push_back(rq);
        end
    endtask

    // Register writes happen only with the pipeline empty; the tracer takes
    // the new value at the same edge as the block.
    task automatic write_reg(input t_cfg_reg idx, input int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[DIM_BITS-1:0];
        @(posedge i_clk);
        if (idx == REG_FRAME_WIDTH) begin
            frame_w = clamp_dim(value[DIM_BITS-1:0]);
        end else begin
            frame_h = clamp_dim(value[DIM_BITS-1:0]);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every request is in and every pixel is out, then lets the
    // pipeline settle, since trailing advances on an idle line emit nothing.
    task automatic drain();
        while (line_reqs.size() != 0 || i_valid || pixel_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_pace(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
        endcase
    endtask

    // Mostly complete short lines anywhere in or just outside the frame with
    // random color, mixed with lines cut short by a new start, long lines that are
    // dropped early, and advances past the end of a line.
    task automatic fill_random(input int budget);
        int done_cnt, kind, span, len, adv, xs, ys, xe, ye;
        done_cnt = 0;
        while (done_cnt < budget) begin
            kind = $urandom_range(99);
            span = ($urandom_range(3) == 0) ? 3 : 24;
            xs = int'($urandom_range(frame_w + 40)) - 20;
            ys = int'($urandom_range(frame_h + 40)) - 20;
            xe = xs + int'($urandom_range(2 * span)) - span;
            ye = ys + int'($urandom_range(2 * span)) - span;
            if (kind < 8) begin
                xs = int'($urandom_range(16383)) - 8192;
                ys = int'($urandom_range(16383)) - 8192;
                xe = int'($urandom_range(16383)) - 8192;
                ye = int'($urandom_range(16383)) - 8192;
            end else if (kind < 28) begin
                ye = ys;
            end else if (kind < 38) begin
                xe = xs;
            end
            len = add_start(xs, ys, xe, ye, $urandom_range(255),
                            $urandom_range(255), $urandom_range(255));
            if (kind < 8) begin
                adv = $urandom_range(1, 20);
            end else if (kind < 18) begin
                adv = $urandom_range(len - 1);
            end else begin
                adv = len;
            end
            add_advances(adv);
            done_cnt += 1 + adv;
            // These land on an idle line and are ignored by the block.
            if (kind >= 90) add_advances($urandom_range(1, 3));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin : stimulus
        int len;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines at the reset frame of 640 by 480, without pacing.
        set_pace(0);
        add_advances(1);                                 // nothing running yet
        len = add_start(0, 0, 0, 0, 0, 0, 0);            // single pixel
        add_advances(len);
        len = add_start(0, 0, 2, 1, 255, 255, 255);      // x-major rising tie
        add_advances(len);
        len = add_start(6, 7, 5, 5, 255, 0, 0);          // y-major, reversed
        add_advances(len);
        len = add_start(639, 479, 637, 480, 0, 255, 0);  // x-major falling tie
        add_advances(len);
        len = add_start(-1, 2, 0, 0, 0, 0, 255);         // y-major falling tie
        add_advances(len);
        len = add_start(-8192, -8192, 8191, 8191, 170, 85, 170);
        add_advances(2);
        // Replaces the line above while it is still running.
        len = add_start(8191, -8192, -8192, 8191, 85, 170, 85);
        add_advances(1);
        drain();

        // Each phase writes both frame registers while a line is still
        // running, resumes that line under the new frame, then runs random
        // traffic and leaves another line unfinished for the next phase.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin write_reg(REG_FRAME_WIDTH, 1);    write_reg(REG_FRAME_HEIGHT, 1);    end
                1: begin write_reg(REG_FRAME_WIDTH, 4096); write_reg(REG_FRAME_HEIGHT, 4096); end
                2: begin write_reg(REG_FRAME_WIDTH, 0);    write_reg(REG_FRAME_HEIGHT, 8191); end
                3: begin
                    write_reg(REG_FRAME_WIDTH, $urandom_range(8191));
                    write_reg(REG_FRAME_HEIGHT, $urandom_range(8191));
                end
                4: begin
                    write_reg(REG_FRAME_WIDTH, $urandom_range(1, 64));
                    write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 64));
                end
                5: begin write_reg(REG_FRAME_WIDTH, 640);  write_reg(REG_FRAME_HEIGHT, 480);  end
                6: begin write_reg(REG_FRAME_WIDTH, 4097); write_reg(REG_FRAME_HEIGHT, 0);    end
                default: begin
                    write_reg(REG_FRAME_WIDTH, 4096);
                    write_reg(REG_FRAME_HEIGHT, 1);
                end
            endcase
            set_pace(ph % 4);
            add_advances(3);
            fill_random(244);
            len = add_start(frame_w - 2, frame_h - 2, frame_w + 6, frame_h + 3,
                            $urandom_range(255), $urandom_range(255),
                            $urandom_range(255));
            add_advances(2);
            drain();
        end

        if (pixel_expect.size() != 0) begin
            log_error($sformatf("%0d pixels never arrived", pixel_expect.size()));
        end
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin : watchdog
        #(4_000_000);
        $display("Timeout with %0d pixels outstanding", pixel_expect.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== line_pixel_generator.f =====
rtl/lpg_pkg.sv
rtl/lpg_queue.sv
rtl/lpg_front.sv
rtl/lpg_step.sv
rtl/lpg_pixel.sv
rtl/line_pixel_generator.sv
tb/sv/tb_top.sv
